// ----- rtl/c_escape_sequence_decoder_unit_assert.svh -----
// Assertion macros for the escape sequence decoder.
`ifndef C_ESCAPE_SEQUENCE_DECODER_UNIT_ASSERT_SVH
`define C_ESCAPE_SEQUENCE_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CESD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CESD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CESD_ASSERT(lbl, prop, msg)
`define CESD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/cesd_pkg.sv -----
// Types, character codes and helper functions for the escape sequence decoder.
package cesd_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_ESC  = 4'b0010,
    MODE_OCT  = 4'b0100,
    MODE_HEX  = 4'b1000
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  acc;
    logic [1:0]  cnt;
  } state_t;

  localparam state_t STATE_CLEAR = '{mode: MODE_IDLE, acc: 8'h00, cnt: 2'd0};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    state_t      nxt;
    logic [1:0]  num;
    res_t        r0;
    res_t        r1;
  } dec_out_t;

  // Control byte for a single-letter escape; anything else maps to itself.
  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      CH_N:    c = 8'h0A;
      CH_T:    c = 8'h09;
      CH_V:    c = 8'h0B;
      CH_B:    c = 8'h08;
      CH_R:    c = 8'h0D;
      CH_F:    c = 8'h0C;
      CH_A:    c = 8'h07;
      default: c = b;
    endcase
    return c;
  endfunction

  // {valid, value} of a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] h;
    if (b >= CH_0 && b <= CH_9) begin
      h = {1'b1, b[3:0]};
    end else if ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF)) begin
      h = {1'b1, b[3:0] + 4'd9};
    end else begin
      h = 5'd0;
    end
    return h;
  endfunction

endpackage

// ----- rtl/cesd_decode.sv -----
// Next-state and result logic for one raw byte.
module cesd_decode
  import cesd_pkg::*;
(
  input  state_t     state_i,
  input  logic [7:0] byte_i,
  input  logic       eos_i,
  output dec_out_t   dec_o
);

  logic       is_oct;
  logic       esc_start;
  logic [4:0] hv;
  logic [7:0] oct_acc;
  logic [1:0] oct_cnt;
  logic [7:0] hex_acc;

  assign is_oct    = (byte_i >= CH_0) && (byte_i <= CH_7);
  assign esc_start = (byte_i == CH_BSLASH) && !eos_i;
  assign hv        = hex_val(byte_i);
  assign oct_acc   = {state_i.acc[4:0], byte_i[2:0]};
  assign oct_cnt   = state_i.cnt + 2'd1;
  assign hex_acc   = {state_i.acc[3:0], hv[3:0]};

  always_comb begin
    dec_o     = '0;
    dec_o.nxt = state_i;
    unique case (state_i.mode)
      MODE_IDLE: begin
        if (esc_start) begin
          dec_o.nxt.mode = MODE_ESC;
        end else begin
          dec_o.num = 2'd1;
          dec_o.r0  = '{data: byte_i, last: eos_i};
          dec_o.nxt = STATE_CLEAR;
        end
      end
      MODE_ESC: begin
        if (byte_i == CH_X) begin
          if (eos_i) begin
            dec_o.num = 2'd1;
            dec_o.r0  = '{data: CH_X, last: 1'b1};
            dec_o.nxt = STATE_CLEAR;
          end else begin
            dec_o.nxt = '{mode: MODE_HEX, acc: 8'h00, cnt: 2'd0};
          end
        end else if (is_oct) begin
          if (eos_i) begin
            dec_o.num = 2'd1;
            dec_o.r0  = '{data: {5'd0, byte_i[2:0]}, last: 1'b1};
            dec_o.nxt = STATE_CLEAR;
          end else begin
            dec_o.nxt = '{mode: MODE_OCT, acc: {5'd0, byte_i[2:0]}, cnt: 2'd1};
          end
        end else begin
          dec_o.num = 2'd1;
          dec_o.r0  = '{data: esc_map(byte_i), last: eos_i};
          dec_o.nxt = STATE_CLEAR;
        end
      end
      MODE_OCT: begin
        if (is_oct) begin
          // third digit (or count wrap, or string end) closes the escape
          if (oct_cnt == 2'd3 || oct_cnt == 2'd0 || eos_i) begin
            dec_o.num = 2'd1;
            dec_o.r0  = '{data: oct_acc, last: eos_i};
            dec_o.nxt = STATE_CLEAR;
          end else begin
            dec_o.nxt = '{mode: MODE_OCT, acc: oct_acc, cnt: oct_cnt};
          end
        end else begin
          // flush pending value, then treat the byte as plain or as a new escape start
          dec_o.r0 = '{data: state_i.acc, last: 1'b0};
          if (esc_start) begin
            dec_o.num = 2'd1;
            dec_o.nxt = '{mode: MODE_ESC, acc: 8'h00, cnt: 2'd0};
          end else begin
            dec_o.num = 2'd2;
            dec_o.r1  = '{data: byte_i, last: eos_i};
            dec_o.nxt = STATE_CLEAR;
          end
        end
      end
      MODE_HEX: begin
        if (hv[4]) begin
          if (eos_i) begin
            dec_o.num = 2'd1;
            dec_o.r0  = '{data: hex_acc, last: 1'b1};
            dec_o.nxt = STATE_CLEAR;
          end else begin
            dec_o.nxt = '{mode: MODE_HEX, acc: hex_acc, cnt: 2'd1};
          end
        end else begin
          // flush the pending value; with no digits seen yet, the 'x' stands for itself
          dec_o.r0 = '{data: (state_i.cnt != 2'd0) ? state_i.acc : CH_X, last: 1'b0};
          if (esc_start) begin
            dec_o.num = 2'd1;
            dec_o.nxt = '{mode: MODE_ESC, acc: 8'h00, cnt: 2'd0};
          end else begin
            dec_o.num = 2'd2;
            dec_o.r1  = '{data: byte_i, last: eos_i};
            dec_o.nxt = STATE_CLEAR;
          end
        end
      end
      default: begin
        dec_o.nxt = STATE_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/c_escape_sequence_decoder_unit.sv -----
// Each accepted byte is registered in the input stage; its results are then queued for output.
// Throughput: one input byte per cycle while the result queue has room for its results; a byte
// that yields two results (a flushed octal/hex value plus the byte itself) needs an empty
// two-entry queue. Bytes that yield no result (backslash, escape digits) add no queue entry.
// Reset (rst_ni low, asynchronous) clears the input stage, the result queue and the
// parse state to idle.
module c_escape_sequence_decoder_unit
  import cesd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // end_of_string
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // string_done
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_eos_q;
  state_t     state_q, state_d;
  res_t       ent_q [2];
  res_t       ent_d [2];
  logic [1:0] cnt_q, cnt_d;

  dec_out_t   dec;
  logic       pop;
  logic       consume;
  logic [1:0] cnt_ap;
  logic [2:0] fill;

  cesd_decode u_decode (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .eos_i   (in_eos_q),
    .dec_o   (dec)
  );

  assign pop     = m_axis_tvalid_o && m_axis_tready_i;
  assign cnt_ap  = cnt_q - {1'b0, pop};
  assign fill    = {1'b0, cnt_ap} + {1'b0, dec.num};
  assign consume = in_vld_q && (fill <= 3'd2);

  assign s_axis_tready_o = !in_vld_q || consume;
  assign in_vld_d        = s_axis_tvalid_i ? 1'b1 : (in_vld_q && !consume);

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = ent_q[0].data;
  assign m_axis_tlast_o  = ent_q[0].last;

  assign state_d = consume ? dec.nxt : state_q;

  always_comb begin
    ent_d[0] = pop ? ent_q[1] : ent_q[0];
    ent_d[1] = ent_q[1];
    cnt_d    = cnt_ap;
    if (consume) begin
      if (cnt_ap == 2'd0) begin
        ent_d[0] = dec.r0;
        ent_d[1] = dec.r1;
      end else if (cnt_ap == 2'd1) begin
        ent_d[1] = dec.r0;
      end
      cnt_d = fill[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= STATE_CLEAR;
      cnt_q    <= 2'd0;
    end else begin
      in_vld_q <= in_vld_d;
      state_q  <= state_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_eos_q  <= s_axis_tlast_i;
    end
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

`include "c_escape_sequence_decoder_unit_assert.svh"

  `CESD_ASSERT(a_cnt_max, cnt_q <= 2'd2, "result queue overfilled")
  `CESD_ASSERT(a_idle_clear,
    (state_q.mode == MODE_IDLE) |-> (state_q.acc == 8'h00 && state_q.cnt == 2'd0),
    "idle state holds stale value")
  `CESD_ASSERT(a_eos_idle, (consume && in_eos_q) |=> (state_q == STATE_CLEAR),
    "string end left escape pending")
  `CESD_ASSERT(a_two_res_room, (consume && dec.num == 2'd2) |-> (cnt_ap == 2'd0),
    "two results taken without room")
  `CESD_ASSERT(a_stall_hold,
    (in_vld_q && !consume) |=> (in_vld_q && $stable(in_byte_q) && $stable(state_q)),
    "stalled byte lost")

endmodule
